// ===== hdl/dnb_pkg.sv =====
// Package for the dual notch biquad cascade: coefficient register map,
// reset values, sequencer term codes and the controller-to-datapath command.
// No dependencies.
package dnb_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int COEF_W    = 16;
    localparam int REG_COUNT = 6;
    localparam int CFG_IDX_W = 3;

    // coefficient register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ZERO_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COS_TERM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_POLE_SQUARE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_ZERO_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COS_TERM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_POLE_SQUARE = 3'd5;

    // reset values, Q2.14
    localparam logic signed [COEF_W-1:0] RST_FIRST_ZERO_GAIN    = 16'sd16300;
    localparam logic signed [COEF_W-1:0] RST_FIRST_COS_TERM     = -16'sd31005;
    localparam logic signed [COEF_W-1:0] RST_FIRST_POLE_SQUARE  = 16'sd16217;
    localparam logic signed [COEF_W-1:0] RST_SECOND_ZERO_GAIN   = 16'sd16284;
    localparam logic signed [COEF_W-1:0] RST_SECOND_COS_TERM    = -16'sd30281;
    localparam logic signed [COEF_W-1:0] RST_SECOND_POLE_SQUARE = 16'sd16184;

    // product terms of one section
    localparam logic [1:0] TERM_ZERO = 2'd0;  // b0 * (x + x2)
    localparam logic [1:0] TERM_COS  = 2'd1;  // b1 * (x1 - y1)
    localparam logic [1:0] TERM_POLE = 2'd2;  // a2 * (-y2)

    localparam logic SEC_FIRST  = 1'b0;
    localparam logic SEC_SECOND = 1'b1;

    typedef struct packed {
        logic       start;     // capture the sample, clear the clip flag
        logic       sec;       // section being worked on
        logic [1:0] term;      // product term fed to the multiplier
        logic       mul_en;    // register a product
        logic       acc_load;  // accumulator = rounding constant + product
        logic       acc_add;   // accumulator += product
        logic       fin;       // shift, saturate, advance the section delays
        logic       out_load;  // load the result register
    } dnb_cmd_t;

endpackage

// ===== hdl/dnb_ctrl.sv =====
// Sequencer for the dual notch biquad cascade: steps one sample through
// both sections and owns the handshake flags. Depends on dnb_pkg.
module dnb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output dnb_pkg::dnb_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       sec_reg, sec_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sec_reg     <= dnb_pkg::SEC_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sec_reg     <= sec_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        cmd          = '0;
        cmd.sec      = sec_reg;
        cmd.term     = dnb_pkg::TERM_ZERO;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    sec_next   = dnb_pkg::SEC_FIRST;
                    state_next = ST_M0;
                end
            end
            ST_M0: begin
                cmd.term   = dnb_pkg::TERM_ZERO;
                cmd.mul_en = 1'b1;
                state_next = ST_M1;
            end
            ST_M1: begin
                cmd.term     = dnb_pkg::TERM_COS;
                cmd.mul_en   = 1'b1;
                cmd.acc_load = 1'b1;
                state_next   = ST_M2;
            end
            ST_M2: begin
                cmd.term    = dnb_pkg::TERM_POLE;
                cmd.mul_en  = 1'b1;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                if (sec_reg == dnb_pkg::SEC_SECOND) begin
                    state_next = ST_DONE;
                end else begin
                    sec_next   = dnb_pkg::SEC_SECOND;
                    state_next = ST_M0;
                end
            end
            ST_DONE: begin
                // hold until the result register is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/dnb_datapath.sv =====
// Datapath for the dual notch biquad cascade: coefficient registers, shared
// multiplier and accumulator, section delay lines and result register.
// Depends on dnb_pkg.
module dnb_datapath #(
    parameter int SAMPLE_BITS    = dnb_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dnb_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dnb_pkg::dnb_cmd_t                    cmd,
    input  logic                                 cfg_wr_en,
    input  logic [dnb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dnb_pkg::COEF_W-1:0]           cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic signed [SAMPLE_BITS-1:0]        sample_out,
    output logic                                 clipped
);

    localparam int OP_W   = SAMPLE_BITS + 1;
    localparam int PROD_W = OP_W + dnb_pkg::COEF_W;
    localparam int ACC_W  = (SAMPLE_BITS + 19 > COEF_FRAC_BITS + 2)
                            ? SAMPLE_BITS + 19 : COEF_FRAC_BITS + 2;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [dnb_pkg::COEF_W-1:0] coef_reg [dnb_pkg::REG_COUNT];

    // delay lines: index 0 previous, index 1 the one before
    logic signed [SAMPLE_BITS-1:0] s1_x0_reg, s1_x1_reg, s1_y0_reg, s1_y1_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x0_reg, s2_x1_reg, s2_y0_reg, s2_y1_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          sat_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_clip_reg;

    logic signed [SAMPLE_BITS-1:0] sec_x, sec_x0, sec_x1, sec_y0, sec_y1;
    logic signed [dnb_pkg::COEF_W-1:0] coef_sel;
    logic signed [OP_W-1:0]        op_sel;
    logic signed [ACC_W-1:0]       acc_shift;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_over;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[dnb_pkg::REG_FIRST_ZERO_GAIN]    <= dnb_pkg::RST_FIRST_ZERO_GAIN;
            coef_reg[dnb_pkg::REG_FIRST_COS_TERM]     <= dnb_pkg::RST_FIRST_COS_TERM;
            coef_reg[dnb_pkg::REG_FIRST_POLE_SQUARE]  <= dnb_pkg::RST_FIRST_POLE_SQUARE;
            coef_reg[dnb_pkg::REG_SECOND_ZERO_GAIN]   <= dnb_pkg::RST_SECOND_ZERO_GAIN;
            coef_reg[dnb_pkg::REG_SECOND_COS_TERM]    <= dnb_pkg::RST_SECOND_COS_TERM;
            coef_reg[dnb_pkg::REG_SECOND_POLE_SQUARE] <= dnb_pkg::RST_SECOND_POLE_SQUARE;
        end else if (cfg_wr_en && (cfg_index < dnb_pkg::CFG_IDX_W'(dnb_pkg::REG_COUNT))) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    // operands of the section in flight
    always_comb begin
        if (cmd.sec == dnb_pkg::SEC_SECOND) begin
            sec_x  = s1_y0_reg;  // first section output, already advanced
            sec_x0 = s2_x0_reg;
            sec_x1 = s2_x1_reg;
            sec_y0 = s2_y0_reg;
            sec_y1 = s2_y1_reg;
        end else begin
            sec_x  = x_reg;
            sec_x0 = s1_x0_reg;
            sec_x1 = s1_x1_reg;
            sec_y0 = s1_y0_reg;
            sec_y1 = s1_y1_reg;
        end
    end

    always_comb begin
        unique case (cmd.term)
            dnb_pkg::TERM_ZERO: begin
                coef_sel = (cmd.sec == dnb_pkg::SEC_SECOND)
                           ? coef_reg[dnb_pkg::REG_SECOND_ZERO_GAIN]
                           : coef_reg[dnb_pkg::REG_FIRST_ZERO_GAIN];
                op_sel   = OP_W'(sec_x) + OP_W'(sec_x1);
            end
            dnb_pkg::TERM_COS: begin
                coef_sel = (cmd.sec == dnb_pkg::SEC_SECOND)
                           ? coef_reg[dnb_pkg::REG_SECOND_COS_TERM]
                           : coef_reg[dnb_pkg::REG_FIRST_COS_TERM];
                op_sel   = OP_W'(sec_x0) - OP_W'(sec_y0);
            end
            default: begin
                coef_sel = (cmd.sec == dnb_pkg::SEC_SECOND)
                           ? coef_reg[dnb_pkg::REG_SECOND_POLE_SQUARE]
                           : coef_reg[dnb_pkg::REG_FIRST_POLE_SQUARE];
                op_sel   = -OP_W'(sec_y1);
            end
        endcase
    end

    // floor shift, then clamp to the sample range
    always_comb begin
        acc_shift = acc_reg >>> COEF_FRAC_BITS;
        y_over    = (acc_shift > ACC_W'(SMAX)) || (acc_shift < ACC_W'(SMIN));
        if (acc_shift > ACC_W'(SMAX)) begin
            y_sat = SMAX;
        end else if (acc_shift < ACC_W'(SMIN)) begin
            y_sat = SMIN;
        end else begin
            y_sat = acc_shift[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_x0_reg <= '0;
            s1_x1_reg <= '0;
            s1_y0_reg <= '0;
            s1_y1_reg <= '0;
            s2_x0_reg <= '0;
            s2_x1_reg <= '0;
            s2_y0_reg <= '0;
            s2_y1_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                sat_reg <= 1'b0;
            end else if (cmd.fin && y_over) begin
                sat_reg <= 1'b1;
            end
            if (cmd.fin) begin
                if (cmd.sec == dnb_pkg::SEC_SECOND) begin
                    s2_x1_reg <= s2_x0_reg;
                    s2_x0_reg <= sec_x;
                    s2_y1_reg <= s2_y0_reg;
                    s2_y0_reg <= y_sat;
                end else begin
                    s1_x1_reg <= s1_x0_reg;
                    s1_x0_reg <= sec_x;
                    s1_y1_reg <= s1_y0_reg;
                    s1_y0_reg <= y_sat;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg <= sample_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(coef_sel) * PROD_W'(op_sel);
        end
        if (cmd.acc_load) begin
            acc_reg <= RND + ACC_W'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.out_load) begin
            out_sample_reg <= s2_y0_reg;
            out_clip_reg   <= sat_reg;
        end
    end

    assign sample_out = out_sample_reg;
    assign clipped    = out_clip_reg;

endmodule

// ===== hdl/dual_notch_biquad_cascade.sv =====
// Top level of the dual notch biquad cascade: two Direct Form I notch
// sections on one shared multiply-accumulate unit.
// Depends on dnb_pkg, dnb_ctrl and dnb_datapath.
//
//  channel  | ports                              | direction
//  ---------+------------------------------------+----------
//  input    | s_valid s_ready s_sample_in        | in
//  result   | m_valid m_ready m_sample_out       | out
//           | m_clipped                          |
//  config   | cfg_wr_en cfg_index cfg_wdata      | in
//
// A sample passes the accept step, then for each section the steps on
// the single registered multiplier (three products, one trailing add, one
// shift-and-saturate step) and a last step that loads the result register.
// The result register parts the two sides: a new sample is taken while an
// earlier result still waits for its transfer; only the load of the next
// result holds until that transfer happens.
// Reset (aresetn, synchronous) clears all delay lines and restores the
// default mains-notch coefficients.
module dual_notch_biquad_cascade #(
    parameter int SAMPLE_BITS    = dnb_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dnb_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_clipped,
    input  logic                          cfg_wr_en,
    input  logic [dnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dnb_pkg::COEF_W-1:0]    cfg_wdata
);

    dnb_pkg::dnb_cmd_t cmd;

    // sequencer: walks both sections, drives the handshake flags
    dnb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // arithmetic, coefficients and filter state
    dnb_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample_in  (s_sample_in),
        .sample_out (m_sample_out),
        .clipped    (m_clipped)
    );

    // a transfer in closes the input until the sample has run both sections
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened straight after a transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##11 !s_ready)
        else $error("sequencer finished a sample too early");

    // a fresh result appears only as the sequencer returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded outside the end of a sample");

    // the start command only follows an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (s_valid && s_ready))
        else $error("sample captured without a transfer");

endmodule
